FILE: hw/rtl/rmts_pkg.sv
// Shared constants, codes and transfer types of the rate-monotonic tick scheduler.
`default_nettype none

package rmts_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int TIME_BITS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TICK_W    = 32;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SLOT_W-1:0]    slot_idx_t;

    typedef struct packed {
        logic      we;
        slot_idx_t addr;
        time_t     period;
        time_t     cost;
    } cfg_wr_t;

    typedef struct packed {
        logic      we;
        slot_idx_t addr;
        time_t     rem;
        time_t     phase;
    } run_wr_t;

    typedef struct packed {
        time_t period;
        time_t cost;
    } cfg_rd_t;

    typedef struct packed {
        time_t rem;
        time_t phase;
    } run_rd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rmts_task_store.sv
// Slot memories: task configuration (period, cost) and run state (remaining work, phase).
`default_nettype none

module rmts_task_store
    import rmts_pkg::*;
(
    input  wire logic      clk,
    input  wire cfg_wr_t   cfg_wr,
    input  wire run_wr_t   run_wr,
    input  wire slot_idx_t rd_addr,
    output cfg_rd_t        cfg_rd,
    output run_rd_t        run_rd
);

    cfg_rd_t cfg_mem [NUM_SLOTS];
    run_rd_t run_mem [NUM_SLOTS];
    cfg_rd_t cfg_rd_reg;
    run_rd_t run_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cfg_wr.we)
        begin
            cfg_mem[cfg_wr.addr] <= '{period: cfg_wr.period, cost: cfg_wr.cost};
        end
        cfg_rd_reg <= cfg_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (run_wr.we)
        begin
            run_mem[run_wr.addr] <= '{rem: run_wr.rem, phase: run_wr.phase};
        end
        run_rd_reg <= run_mem[rd_addr];
    end

    assign cfg_rd = cfg_rd_reg;
    assign run_rd = run_rd_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rmts_sched_ctrl.sv
// Scheduler sequencer: task load, restart clear, slot scan, release, priority pick, phase advance and result.
`default_nettype none

module rmts_sched_ctrl
    import rmts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  slot,
    input  wire logic [15:0] task_period,
    input  wire logic [15:0] task_cost,
    output logic             busy,
    output logic             done,
    output logic             busy_res,
    output logic [3:0]       running_slot,
    output logic [31:0]      tick_number,
    output cfg_wr_t          cfg_wr,
    output run_wr_t          run_wr,
    output slot_idx_t        rd_addr,
    input  wire cfg_rd_t     cfg_rd,
    input  wire run_rd_t     run_rd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_LAST  = 5'b00100,
        ST_FIN   = 5'b01000,
        ST_CLEAR = 5'b10000
    } state_t;

    localparam slot_idx_t LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    state_t                 state_reg, state_next;
    slot_idx_t              idx_reg, idx_next;
    logic                   pv_reg;
    slot_idx_t              pidx_reg;
    logic [NUM_SLOTS-1:0]   enabled_reg, enabled_next;
    logic                   have_reg, have_next;
    time_t                  best_reg, best_next;
    slot_idx_t              win_reg, win_next;
    time_t                  win_rem_reg, win_rem_next;
    time_t                  win_phase_reg, win_phase_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic                   done_reg, done_next;
    logic                   busy_res_reg, busy_res_next;
    logic [3:0]             run_slot_reg, run_slot_next;
    logic [TICK_W-1:0]      tick_out_reg, tick_out_next;

    logic      accept;
    logic      load_ok;
    logic      en_p;
    time_t     rem0;
    time_t     phase_adv;
    time_t     phase_new;
    logic      cand;
    logic [TIME_BITS:0] phase_inc;

    assign accept  = start && (state_reg == ST_IDLE);
    assign load_ok = accept && (kind == KIND_LOAD) && (32'(slot) < NUM_SLOTS);

    // Release, candidate test and phase advance for the slot whose data just came back.
    always_comb
    begin
        en_p      = enabled_reg[pidx_reg];
        rem0      = (en_p && (run_rd.phase == '0)) ? cfg_rd.cost : run_rd.rem;
        phase_inc = {1'b0, run_rd.phase} + 1'b1;
        if (phase_inc[TIME_BITS] || (phase_inc[TIME_BITS-1:0] >= cfg_rd.period))
        begin
            phase_adv = '0;
        end
        else
        begin
            phase_adv = phase_inc[TIME_BITS-1:0];
        end
        phase_new = en_p ? phase_adv : run_rd.phase;
        cand      = pv_reg && en_p && (rem0 != '0) && (!have_reg || (cfg_rd.period < best_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        enabled_next   = enabled_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        win_next       = win_reg;
        win_rem_next   = win_rem_reg;
        win_phase_next = win_phase_reg;
        tick_next      = tick_reg;
        done_next      = 1'b0;
        busy_res_next  = busy_res_reg;
        run_slot_next  = run_slot_reg;
        tick_out_next  = tick_out_reg;

        cfg_wr = '{we: load_ok, addr: SLOT_W'(slot),
                   period: TIME_BITS'(task_period), cost: TIME_BITS'(task_cost)};
        run_wr = '{we: 1'b0, addr: SLOT_W'(slot), rem: '0, phase: '0};

        if (cand)
        begin
            have_next      = 1'b1;
            best_next      = cfg_rd.period;
            win_next       = pidx_reg;
            win_rem_next   = rem0;
            win_phase_next = phase_new;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_ok)
                begin
                    run_wr.we = 1'b1;
                    enabled_next[SLOT_W'(slot)] = (TIME_BITS'(task_period) != '0);
                end
                if (accept && (kind == KIND_TICK))
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                    have_next  = 1'b0;
                end
                if (accept && (kind == KIND_RESTART))
                begin
                    state_next = ST_CLEAR;
                    idx_next   = '0;
                    tick_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // The winner was already written back with its released work; charge one tick.
                if (have_reg)
                begin
                    run_wr = '{we: 1'b1, addr: win_reg, rem: win_rem_reg - 1'b1,
                               phase: win_phase_reg};
                end
                done_next     = 1'b1;
                busy_res_next = have_reg;
                run_slot_next = have_reg ? 4'(win_reg) : 4'd0;
                tick_out_next = tick_reg;
                tick_next     = tick_reg + 1'b1;
                state_next    = ST_IDLE;
            end
            ST_CLEAR:
            begin
                run_wr = '{we: 1'b1, addr: idx_reg, rem: '0, phase: '0};
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (pv_reg)
        begin
            run_wr = '{we: 1'b1, addr: pidx_reg, rem: rem0, phase: phase_new};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            pv_reg       <= 1'b0;
            pidx_reg     <= '0;
            enabled_reg  <= '0;
            have_reg     <= 1'b0;
            tick_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            pv_reg       <= (state_reg == ST_SCAN);
            pidx_reg     <= idx_reg;
            enabled_reg  <= enabled_next;
            have_reg     <= have_next;
            tick_reg     <= tick_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        win_reg       <= win_next;
        win_rem_reg   <= win_rem_next;
        win_phase_reg <= win_phase_next;
        busy_res_reg  <= busy_res_next;
        run_slot_reg  <= run_slot_next;
        tick_out_reg  <= tick_out_next;
    end

    assign rd_addr      = idx_reg;
    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign busy_res     = busy_res_reg;
    assign running_slot = run_slot_reg;
    assign tick_number  = tick_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rate_monotonic_tick_scheduler.sv
// A tick runs through the slot scan, then the LAST and FIN states, before done rises.
// Load transactions complete at the accept edge and leave busy low; no result is produced.
// Restart transactions hold busy while the run-state memory is cleared slot by slot.
// Ticks are accepted only after the previous tick finishes; loads every cycle while idle.
// One tick is handled at a time; done pulses for one cycle and the receiver cannot stall it.
// After rst_n all slots are disabled and the tick count is zero; memories need no clearing.
`default_nettype none

module rate_monotonic_tick_scheduler
    import rmts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  slot,
    input  wire logic [15:0] task_period,
    input  wire logic [15:0] task_cost,
    output logic             done,
    output logic             busy_res,
    output logic [3:0]       running_slot,
    output logic [31:0]      tick_number
);

    cfg_wr_t   cfg_wr;
    run_wr_t   run_wr;
    slot_idx_t rd_addr;
    cfg_rd_t   cfg_rd;
    run_rd_t   run_rd;

    rmts_sched_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .slot         (slot),
        .task_period  (task_period),
        .task_cost    (task_cost),
        .busy         (busy),
        .done         (done),
        .busy_res     (busy_res),
        .running_slot (running_slot),
        .tick_number  (tick_number),
        .cfg_wr       (cfg_wr),
        .run_wr       (run_wr),
        .rd_addr      (rd_addr),
        .cfg_rd       (cfg_rd),
        .run_rd       (run_rd)
    );

    rmts_task_store u_store (
        .clk     (clk),
        .cfg_wr  (cfg_wr),
        .run_wr  (run_wr),
        .rd_addr (rd_addr),
        .cfg_rd  (cfg_rd),
        .run_rd  (run_rd)
    );

endmodule

`default_nettype wire

FILE: verif/rate_monotonic_tick_scheduler_test.sv
// Self-checking testbench for the rate-monotonic tick scheduler: directed table, then random.
`timescale 1ns / 1ps

module rate_monotonic_tick_scheduler_test;
    import rmts_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 600;
    localparam int         CALM_ITEMS   = 100;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 2 * NUM_SLOTS + 8;

    typedef struct packed {
        logic        busy_res;
        logic [3:0]  running_slot;
        logic [31:0] tick_number;
    } tick_result_t;

    typedef struct {
        logic [1:0]   kind;
        logic [3:0]   slot;
        logic [15:0]  period;
        logic [15:0]  cost;
        bit           typed;
        tick_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  kind = '0;
    logic [3:0]  slot = '0;
    logic [15:0] task_period = '0;
    logic [15:0] task_cost = '0;
    logic        busy;
    logic        done;
    logic        busy_res;
    logic [3:0]  running_slot;
    logic [31:0] tick_number;

    // Predicted scheduler state.
    time_t       sched_period [NUM_SLOTS];
    time_t       sched_cost   [NUM_SLOTS];
    time_t       sched_rem    [NUM_SLOTS];
    time_t       sched_phase  [NUM_SLOTS];
    bit          sched_en     [NUM_SLOTS];
    logic [31:0] sched_ticks;

    tick_result_t pending_ticks[$];
    stim_row_t    directed_rows[$];
    int           error_count = 0;
    int           stall_cycles = 0;

    rate_monotonic_tick_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .slot         (slot),
        .task_period  (task_period),
        .task_cost    (task_cost),
        .done         (done),
        .busy_res     (busy_res),
        .running_slot (running_slot),
        .tick_number  (tick_number)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
        error_count++;
    endtask

    function automatic void clear_schedule();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            sched_rem[i]   = '0;
            sched_phase[i] = '0;
        end
        sched_ticks = '0;
    endfunction

    // Applies one transaction to the predicted state; only ticks produce a result.
    function automatic void schedule_step(input logic [1:0] k, input logic [3:0] s,
                                          input logic [15:0] p, input logic [15:0] c,
                                          output bit produced, output tick_result_t res);
        int                 winner;
        time_t              best;
        logic [TIME_BITS:0] nx;
        winner   = -1;
        best     = '0;
        produced = 1'b0;
        res      = '0;
        if (k == KIND_LOAD)
        begin
            sched_period[s] = p;
            sched_cost[s]   = c;
            sched_en[s]     = (p != 0);
            sched_rem[s]    = '0;
            sched_phase[s]  = '0;
        end
        else if (k == KIND_RESTART)
        begin
            clear_schedule();
        end
        else if (k == KIND_TICK)
        begin
            // Release first: unfinished work from the previous period is dropped.
            for (int i = 0; i < NUM_SLOTS; i++)
                if (sched_en[i] && sched_phase[i] == 0)
                    sched_rem[i] = sched_cost[i];
            for (int i = 0; i < NUM_SLOTS; i++)
                if (sched_en[i] && sched_rem[i] != 0 && (winner < 0 || sched_period[i] < best))
                begin
                    winner = i;
                    best   = sched_period[i];
                end
            if (winner >= 0)
                sched_rem[winner] = sched_rem[winner] - 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (sched_en[i])
                begin
                    nx = {1'b0, sched_phase[i]} + 1'b1;
                    if (nx >= {1'b0, sched_period[i]} || nx[TIME_BITS])
                        nx = '0;
                    sched_phase[i] = nx[TIME_BITS-1:0];
                end
            produced         = 1'b1;
            res.busy_res     = (winner >= 0);
            res.running_slot = (winner >= 0) ? winner[3:0] : 4'd0;
            res.tick_number  = sched_ticks;
            sched_ticks      = sched_ticks + 1'b1;
        end
    endfunction

    function automatic void add_row(input logic [1:0] k, input logic [3:0] s,
                                    input logic [15:0] p, input logic [15:0] c,
                                    input bit typed = 1'b0, input logic b = 1'b0,
                                    input logic [3:0] rs = '0, input logic [31:0] tn = '0);
        stim_row_t row;
        row.kind   = k;
        row.slot   = s;
        row.period = p;
        row.cost   = c;
        row.typed  = typed;
        row.want   = '{busy_res: b, running_slot: rs, tick_number: tn};
        directed_rows.push_back(row);
    endfunction

    // Presents one transaction, holds it until accepted, then, for a nonzero gap, drops start and idles for that gap.
    task automatic send_item(input stim_row_t row, input int gap);
        bit           produced;
        tick_result_t res;
        start       <= 1'b1;
        kind        <= row.kind;
        slot        <= row.slot;
        task_period <= row.period;
        task_cost   <= row.cost;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        schedule_step(row.kind, row.slot, row.period, row.cost, produced, res);
        if (produced)
            pending_ticks.push_back(row.typed ? row.want : res);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int pick_gap(input bit calm);
        if (calm || $urandom_range(3) != 0)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t   row;
        int unsigned r;
        int unsigned shape;
        row.typed  = 1'b0;
        row.want   = '0;
        row.slot   = 4'($urandom_range(15));
        row.period = 16'($urandom);
        row.cost   = 16'($urandom);
        r          = $urandom_range(99);
        if (r < 55)
            row.kind = KIND_TICK;
        else if (r < 88)
            row.kind = KIND_LOAD;
        else if (r < 95)
            row.kind = KIND_RESTART;
        else
            row.kind = KIND_UNUSED;
        if (row.kind == KIND_LOAD)
        begin
            // Mostly short periods so that releases and preemption happen often.
            shape = $urandom_range(15);
            if (shape == 1)
            begin
                row.period = '0;
            end
            else if (shape > 1)
            begin
                row.period = 16'($urandom_range(1, 12));
                row.cost   = 16'($urandom_range(0, row.period + 1));
            end
        end
        return row;
    endfunction

    initial
    begin
        stim_row_t row;
        int        counted;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            sched_period[i] = '0;
            sched_cost[i]   = '0;
            sched_en[i]     = 1'b0;
        end
        clear_schedule();

        add_row(KIND_TICK,    4'd0,  16'd0,     16'd0,     1'b1, 1'b0, 4'd0, 32'd0);
        add_row(KIND_UNUSED,  4'd5,  16'hFFFF,  16'hFFFF);
        add_row(KIND_TICK,    4'd0,  16'd0,     16'd0,     1'b1, 1'b0, 4'd0, 32'd1);
        add_row(KIND_LOAD,    4'd15, 16'hFFFF,  16'hFFFF);
        add_row(KIND_LOAD,    4'd0,  16'd0,     16'd5);
        add_row(KIND_LOAD,    4'd3,  16'd4,     16'd2);
        add_row(KIND_LOAD,    4'd7,  16'd4,     16'd1);
        add_row(KIND_LOAD,    4'd9,  16'd2,     16'd0);
        for (int i = 0; i < 6; i++)
            add_row(KIND_TICK, 4'd0, 16'd0, 16'd0);
        add_row(KIND_LOAD,    4'd3,  16'd1,     16'd1);
        add_row(KIND_TICK,    4'd0,  16'd0,     16'd0);
        add_row(KIND_TICK,    4'd0,  16'd0,     16'd0);
        add_row(KIND_RESTART, 4'd0,  16'd0,     16'd0);
        add_row(KIND_TICK,    4'd0,  16'd0,     16'd0);
        add_row(KIND_LOAD,    4'd15, 16'd0,     16'd0);
        add_row(KIND_LOAD,    4'd3,  16'd0,     16'd0);
        add_row(KIND_TICK,    4'd0,  16'd0,     16'd0);
        add_row(KIND_TICK,    4'd0,  16'd0,     16'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i], pick_gap(1'b0));

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            row = random_row();
            if (row.kind != KIND_UNUSED)
                counted++;
            send_item(row, pick_gap(counted > RANDOM_ITEMS - CALM_ITEMS));
        end
        start <= 1'b0;

        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[rate_monotonic_tick_scheduler] OK");
        else
            $display("[rate_monotonic_tick_scheduler] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && done)
        begin
            if (pending_ticks.size() == 0)
            begin
                report_mismatch("unexpected result tick_number", tick_number, 0);
            end
            else
            begin
                want = pending_ticks.pop_front();
                if (busy_res !== want.busy_res)
                    report_mismatch("busy_res", busy_res, want.busy_res);
                if (running_slot !== want.running_slot)
                    report_mismatch("running_slot", running_slot, want.running_slot);
                if (tick_number !== want.tick_number)
                    report_mismatch("tick_number", tick_number, want.tick_number);
            end
        end
    end

    // Ends the run when neither a transaction nor a result moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without a transaction", stall_cycles);
            $display("[rate_monotonic_tick_scheduler] ERROR");
            $finish;
        end
    end

endmodule
